FILE: rtl/mfdu_pkg.sv
// Shared types, constants and configuration layout for the motor feedback
// decoder with multi-turn unwrap. No dependencies.
package mfdu_pkg;

  // Encoder and count geometry.
  localparam int ENC_COUNTS = 8192;
  localparam int ENC_W      = 16;
  localparam int STEP_W     = 19;
  localparam int CNT_W      = 48;
  localparam int DEG_W      = 32;
  localparam int HOT_W      = 10;
  localparam int ID_W       = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Split of the count magnitude for the partial products.
  localparam int MAG_LO_W = 32;
  localparam int MAG_HI_W = CNT_W - MAG_LO_W;
  localparam int PROD_W   = CNT_W + DEG_W;
  localparam int FRAC_W   = 16;
  localparam int RND_W    = PROD_W - FRAC_W;

  localparam logic signed [STEP_W-1:0] ENC_N = STEP_W'(ENC_COUNTS);
  localparam logic signed [CNT_W-1:0]  CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0]  CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

  // Identifier boundaries for the command group decode.
  localparam logic [ID_W-1:0] RX_MIDDLE = 11'h204;
  localparam logic [ID_W-1:0] RX_LOW    = 11'h200;

  // Register reset values.
  localparam logic [ID_W-1:0]  RST_RX_ID       = 11'd513;
  localparam logic [DEG_W-1:0] RST_DEG         = 32'd150000;
  localparam logic [7:0]       RST_TEMP_LIMIT  = 8'd50;
  localparam logic [HOT_W-1:0] RST_COUNT_LIMIT = 10'd500;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RX_ID            = 3'd0,
    CFG_MOTOR_TYPE       = 3'd1,
    CFG_DEG_PER_COUNT    = 3'd2,
    CFG_TEMP_LIMIT       = 3'd3,
    CFG_TEMP_COUNT_LIMIT = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MT_SINGLE   = 2'd0,
    MT_GEARED_A = 2'd1,
    MT_GEARED_B = 2'd2,
    MT_NO_ANGLE = 2'd3
  } mtype_t;

  typedef enum logic [1:0] {
    GRP_NONE = 2'd0,
    GRP_LOW  = 2'd1,
    GRP_HIGH = 2'd2,
    GRP_VOLT = 2'd3
  } grp_t;

  typedef struct packed {
    logic [ID_W-1:0]  rx_id;
    mtype_t           motor_type;
    logic [DEG_W-1:0] deg_per_count;
    logic [7:0]       temp_limit;
    logic [HOT_W-1:0] temp_count_limit;
  } cfg_t;

  // Held feedback state that rides along with each word.
  typedef struct packed {
    logic              matched;
    logic [ENC_W-1:0]  encoder;
    logic [15:0]       speed;
    logic [15:0]       current;
    logic [7:0]        temp;
    logic              over_temp;
    grp_t              group;
    logic [3:0]        slot;
  } fb_t;

endpackage

FILE: rtl/mfdu_track.sv
// Input register and per-frame state update: decode, temperature tracking,
// group/slot decode and encoder unwrap. Depends on mfdu_pkg.
module mfdu_track (
  input  logic                            clk,
  input  logic                            rst_n,
  input  mfdu_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [mfdu_pkg::ID_W-1:0]       in_frame_id,
  input  logic [7:0]                      in_data_b0,
  input  logic [7:0]                      in_data_b1,
  input  logic [7:0]                      in_data_b2,
  input  logic [7:0]                      in_data_b3,
  input  logic [7:0]                      in_data_b4,
  input  logic [7:0]                      in_data_b5,
  input  logic [7:0]                      in_data_b6,
  output logic                            s1_valid,
  input  logic                            s1_ready,
  output mfdu_pkg::fb_t                   s1_fb,
  output logic signed [mfdu_pkg::CNT_W-1:0] s1_count
);
  import mfdu_pkg::*;

  // Input stage registers.
  logic             s0_v_r;
  logic [ID_W-1:0]  s0_fid_r;
  logic [ENC_W-1:0] s0_enc_r;
  logic [15:0]      s0_spd_r;
  logic [15:0]      s0_cur_r;
  logic [7:0]       s0_tmp_r;

  // Block state.
  logic                    started_r, started_nxt;
  logic [ENC_W-1:0]        prev_encoder_r, prev_encoder_nxt;
  logic signed [CNT_W-1:0] turn_count_r, turn_count_nxt;
  logic [HOT_W-1:0]        hot_frames_r, hot_frames_nxt;
  logic                    hot_flag_r, hot_flag_nxt;
  logic [15:0]             last_speed_r, last_speed_nxt;
  logic [15:0]             last_current_r, last_current_nxt;
  logic [7:0]              last_temp_r, last_temp_nxt;
  logic [ENC_W-1:0]        last_encoder_r, last_encoder_nxt;
  grp_t                    cmd_group_r, cmd_group_nxt;
  logic [3:0]              cmd_slot_r, cmd_slot_nxt;

  // Result stage registers.
  logic                    s1_v_r;
  fb_t                     s1_fb_r;
  logic signed [CNT_W-1:0] s1_count_r;

  logic rdy0, rdy1, s0_adv, hit;

  assign rdy1     = !s1_v_r || s1_ready;
  assign rdy0     = !s0_v_r || rdy1;
  assign s0_adv   = s0_v_r && rdy1;
  assign in_stall = !rdy0;
  assign hit      = (s0_fid_r == cfg.rx_id);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (rdy0) begin
      s0_v_r <= in_valid;
    end
    if (rdy0 && in_valid) begin
      s0_fid_r <= in_frame_id;
      s0_enc_r <= {in_data_b0, in_data_b1};
      s0_spd_r <= {in_data_b2, in_data_b3};
      s0_cur_r <= {in_data_b4, in_data_b5};
      s0_tmp_r <= in_data_b6;
    end
  end

  // Next state for one matched frame.
  always_comb begin
    logic [HOT_W-1:0]         hf_inc;
    logic [ID_W-1:0]          id_off;
    logic [ENC_W-1:0]         prev_eff;
    logic signed [CNT_W-1:0]  base;
    logic signed [STEP_W-1:0] d, alt, aa, ad, step;
    logic signed [CNT_W:0]    sum;

    started_nxt      = started_r;
    prev_encoder_nxt = prev_encoder_r;
    turn_count_nxt   = turn_count_r;
    hot_frames_nxt   = hot_frames_r;
    hot_flag_nxt     = hot_flag_r;
    last_speed_nxt   = last_speed_r;
    last_current_nxt = last_current_r;
    last_temp_nxt    = last_temp_r;
    last_encoder_nxt = last_encoder_r;
    cmd_group_nxt    = cmd_group_r;
    cmd_slot_nxt     = cmd_slot_r;

    hf_inc   = (hot_frames_r == '1) ? hot_frames_r : hot_frames_r + 1'b1;
    id_off   = '0;
    prev_eff = started_r ? prev_encoder_r : s0_enc_r;
    if (started_r) begin
      base = turn_count_r;
    end else if (cfg.motor_type == MT_SINGLE) begin
      base = CNT_W'(s0_enc_r);
    end else begin
      base = '0;
    end

    // Encoder step, wrapped to the shorter way around.
    d = $signed(STEP_W'(s0_enc_r) - STEP_W'(prev_eff));
    if (d < 0) begin
      alt = d + ENC_N;
    end else if (d > 0) begin
      alt = d - ENC_N;
    end else begin
      alt = '0;
    end
    aa = (alt < 0) ? -alt : alt;
    ad = (d < 0) ? -d : d;
    if (cfg.motor_type == MT_SINGLE) begin
      if ((d <<< 1) > ENC_N) begin
        step = d - ENC_N;
      end else if ((d <<< 1) < -ENC_N) begin
        step = d + ENC_N;
      end else begin
        step = d;
      end
    end else begin
      step = (aa > ad) ? d : alt;
    end
    sum = $signed({base[CNT_W-1], base}) + (CNT_W+1)'(step);

    if (s0_adv && hit) begin
      last_encoder_nxt = s0_enc_r;
      last_speed_nxt   = s0_spd_r;
      last_current_nxt = s0_cur_r;
      last_temp_nxt    = s0_tmp_r;

      // Over-temperature frame counting with a sticky flag.
      if (s0_tmp_r > cfg.temp_limit) begin
        if (hf_inc > cfg.temp_count_limit) begin
          hot_flag_nxt   = 1'b1;
          hot_frames_nxt = '0;
        end else begin
          hot_frames_nxt = hf_inc;
        end
      end else begin
        hot_frames_nxt = '0;
      end

      // Command group and slot from the identifier, until started.
      if (!started_r) begin
        if (cfg.rx_id > RX_MIDDLE) begin
          cmd_group_nxt = (cfg.motor_type == MT_SINGLE) ? GRP_VOLT : GRP_HIGH;
          id_off        = cfg.rx_id - (RX_MIDDLE + 1'b1);
          cmd_slot_nxt  = {id_off[2:0], 1'b0};
        end else if (cfg.rx_id > RX_LOW) begin
          cmd_group_nxt = GRP_LOW;
          id_off        = cfg.rx_id - (RX_LOW + 1'b1);
          cmd_slot_nxt  = {id_off[2:0], 1'b0};
        end
      end

      // Multi-turn count, saturated to the count range.
      if (cfg.motor_type != MT_NO_ANGLE) begin
        started_nxt      = 1'b1;
        prev_encoder_nxt = s0_enc_r;
        if (sum[CNT_W] != sum[CNT_W-1]) begin
          turn_count_nxt = sum[CNT_W] ? CNT_MIN : CNT_MAX;
        end else begin
          turn_count_nxt = sum[CNT_W-1:0];
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r      <= 1'b0;
      prev_encoder_r <= '0;
      turn_count_r   <= '0;
      hot_frames_r   <= '0;
      hot_flag_r     <= 1'b0;
      last_speed_r   <= '0;
      last_current_r <= '0;
      last_temp_r    <= '0;
      last_encoder_r <= '0;
      cmd_group_r    <= GRP_NONE;
      cmd_slot_r     <= '0;
    end else begin
      started_r      <= started_nxt;
      prev_encoder_r <= prev_encoder_nxt;
      turn_count_r   <= turn_count_nxt;
      hot_frames_r   <= hot_frames_nxt;
      hot_flag_r     <= hot_flag_nxt;
      last_speed_r   <= last_speed_nxt;
      last_current_r <= last_current_nxt;
      last_temp_r    <= last_temp_nxt;
      last_encoder_r <= last_encoder_nxt;
      cmd_group_r    <= cmd_group_nxt;
      cmd_slot_r     <= cmd_slot_nxt;
    end
  end

  // Snapshot of the updated state for this word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (rdy1) begin
      s1_v_r <= s0_v_r;
    end
    if (s0_adv) begin
      s1_fb_r.matched   <= hit;
      s1_fb_r.encoder   <= last_encoder_nxt;
      s1_fb_r.speed     <= last_speed_nxt;
      s1_fb_r.current   <= last_current_nxt;
      s1_fb_r.temp      <= last_temp_nxt;
      s1_fb_r.over_temp <= hot_flag_nxt;
      s1_fb_r.group     <= cmd_group_nxt;
      s1_fb_r.slot      <= cmd_slot_nxt;
      s1_count_r        <= turn_count_nxt;
    end
  end

  assign s1_valid = s1_v_r;
  assign s1_fb    = s1_fb_r;
  assign s1_count = s1_count_r;

  // The over-temperature flag never clears outside reset.
  a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    hot_flag_r |=> hot_flag_r)
    else $error("over-temperature flag cleared");

  // A frame for another identifier leaves the unwrap state alone.
  a_miss_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s0_adv && !hit |=> $stable(turn_count_r) && $stable(prev_encoder_r)
                       && $stable(started_r))
    else $error("unmatched frame changed unwrap state");

  // A matched frame in an angle mode leaves the unwrap started.
  a_start_sets: assert property (@(posedge clk) disable iff (!rst_n)
    s0_adv && hit && cfg.motor_type != MT_NO_ANGLE |=> started_r)
    else $error("unwrap not started after matched frame");

endmodule

FILE: rtl/mfdu_scale.sv
// Angle scaling pipeline: count magnitude, partial products, rounding,
// saturation and the result register. Depends on mfdu_pkg.
module mfdu_scale (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [mfdu_pkg::DEG_W-1:0]        deg_per_count,
  input  logic                              s1_valid,
  output logic                              s1_ready,
  input  mfdu_pkg::fb_t                     s1_fb,
  input  logic signed [mfdu_pkg::CNT_W-1:0] s1_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_matched,
  output logic [15:0]                       out_encoder_pos,
  output logic signed [15:0]                out_speed,
  output logic signed [15:0]                out_torque_current,
  output logic [7:0]                        out_temp_reading,
  output logic signed [mfdu_pkg::CNT_W-1:0] out_angle_deg,
  output logic                              out_over_temp,
  output logic [1:0]                        out_tx_group,
  output logic [3:0]                        out_tx_slot
);
  import mfdu_pkg::*;

  localparam logic [RND_W-1:0] NEG_LIM  = RND_W'(1) << (CNT_W - 1);
  localparam logic [RND_W-1:0] POS_LIM  = NEG_LIM - 1'b1;
  localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_W - 1);

  logic v2_r, v3_r, v4_r, out_v_r;
  logic rdy2, rdy3, rdy4, rdy5;
  fb_t  fb2_r, fb3_r, fb4_r, fb5_r;
  logic neg2_r, neg3_r, neg4_r;
  logic [CNT_W-1:0]          mag2_r;
  logic [MAG_LO_W+DEG_W-1:0] pp_lo_r;
  logic [MAG_HI_W+DEG_W-1:0] pp_hi_r;
  logic [RND_W-1:0]          rnd4_r;
  logic signed [CNT_W-1:0]   angle_r;
  logic [PROD_W-1:0]         full;
  logic [RND_W-1:0]          clip;

  assign rdy5     = !out_v_r || !out_stall;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign s1_ready = rdy2;

  // Rounded product and its clip to the signed result range.
  assign full = {pp_hi_r, {MAG_LO_W{1'b0}}} + PROD_W'(pp_lo_r) + HALF_LSB;
  always_comb begin
    if (neg4_r) begin
      clip = (rnd4_r > NEG_LIM) ? NEG_LIM : rnd4_r;
    end else begin
      clip = (rnd4_r > POS_LIM) ? POS_LIM : rnd4_r;
    end
  end

  // Word valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      v4_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_r <= s1_valid;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
      if (rdy5) begin
        out_v_r <= v4_r;
      end
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid) begin
      fb2_r  <= s1_fb;
      neg2_r <= s1_count[CNT_W-1];
      mag2_r <= s1_count[CNT_W-1] ? CNT_W'(-s1_count) : CNT_W'(s1_count);
    end
    if (rdy3 && v2_r) begin
      fb3_r   <= fb2_r;
      neg3_r  <= neg2_r;
      pp_lo_r <= (MAG_LO_W+DEG_W)'(mag2_r[MAG_LO_W-1:0])
                 * (MAG_LO_W+DEG_W)'(deg_per_count);
      pp_hi_r <= (MAG_HI_W+DEG_W)'(mag2_r[CNT_W-1:MAG_LO_W])
                 * (MAG_HI_W+DEG_W)'(deg_per_count);
    end
    if (rdy4 && v3_r) begin
      fb4_r  <= fb3_r;
      neg4_r <= neg3_r;
      rnd4_r <= full[PROD_W-1:FRAC_W];
    end
    if (rdy5 && v4_r) begin
      fb5_r   <= fb4_r;
      angle_r <= neg4_r ? -$signed(clip[CNT_W-1:0]) : $signed(clip[CNT_W-1:0]);
    end
  end

  assign out_valid          = out_v_r;
  assign out_matched        = fb5_r.matched;
  assign out_encoder_pos    = fb5_r.encoder;
  assign out_speed          = $signed(fb5_r.speed);
  assign out_torque_current = $signed(fb5_r.current);
  assign out_temp_reading   = fb5_r.temp;
  assign out_angle_deg      = angle_r;
  assign out_over_temp      = fb5_r.over_temp;
  assign out_tx_group       = fb5_r.group;
  assign out_tx_slot        = fb5_r.slot;

endmodule

FILE: rtl/motor_feedback_decode_unwrap.sv
// Throughput: one frame per cycle while out_stall is low; the stage chain is a
// six-register pipeline whose bubbles fill while a result word waits on out_stall.
// The angle multiply is split into two partial products over one stage.
// Reset (rst_n low, synchronous) clears the valid bits and block state and loads register defaults.
// Holds the configuration registers; depends on mfdu_pkg, mfdu_track, mfdu_scale.
module motor_feedback_decode_unwrap (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [mfdu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mfdu_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [10:0]                          in_frame_id,
  input  logic [7:0]                           in_data_b0,
  input  logic [7:0]                           in_data_b1,
  input  logic [7:0]                           in_data_b2,
  input  logic [7:0]                           in_data_b3,
  input  logic [7:0]                           in_data_b4,
  input  logic [7:0]                           in_data_b5,
  input  logic [7:0]                           in_data_b6,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_matched,
  output logic [15:0]                          out_encoder_pos,
  output logic signed [15:0]                   out_speed,
  output logic signed [15:0]                   out_torque_current,
  output logic [7:0]                           out_temp_reading,
  output logic signed [47:0]                   out_angle_deg,
  output logic                                 out_over_temp,
  output logic [1:0]                           out_tx_group,
  output logic [3:0]                           out_tx_slot
);
  import mfdu_pkg::*;

  cfg_t                    cfg_r;
  logic                    s1_valid, s1_ready;
  fb_t                     s1_fb;
  logic signed [CNT_W-1:0] s1_count;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rx_id            <= RST_RX_ID;
      cfg_r.motor_type       <= MT_GEARED_A;
      cfg_r.deg_per_count    <= RST_DEG;
      cfg_r.temp_limit       <= RST_TEMP_LIMIT;
      cfg_r.temp_count_limit <= RST_COUNT_LIMIT;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RX_ID:            cfg_r.rx_id            <= cfg_data[ID_W-1:0];
        CFG_MOTOR_TYPE:       cfg_r.motor_type       <= mtype_t'(cfg_data[1:0]);
        CFG_DEG_PER_COUNT:    cfg_r.deg_per_count    <= cfg_data[DEG_W-1:0];
        CFG_TEMP_LIMIT:       cfg_r.temp_limit       <= cfg_data[7:0];
        CFG_TEMP_COUNT_LIMIT: cfg_r.temp_count_limit <= cfg_data[HOT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Frame decode and state update.
  mfdu_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_frame_id (in_frame_id),
    .in_data_b0  (in_data_b0),
    .in_data_b1  (in_data_b1),
    .in_data_b2  (in_data_b2),
    .in_data_b3  (in_data_b3),
    .in_data_b4  (in_data_b4),
    .in_data_b5  (in_data_b5),
    .in_data_b6  (in_data_b6),
    .s1_valid    (s1_valid),
    .s1_ready    (s1_ready),
    .s1_fb       (s1_fb),
    .s1_count    (s1_count)
  );

  // Angle scaling and result register.
  mfdu_scale u_scale (
    .clk                (clk),
    .rst_n              (rst_n),
    .deg_per_count      (cfg_r.deg_per_count),
    .s1_valid           (s1_valid),
    .s1_ready           (s1_ready),
    .s1_fb              (s1_fb),
    .s1_count           (s1_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_matched        (out_matched),
    .out_encoder_pos    (out_encoder_pos),
    .out_speed          (out_speed),
    .out_torque_current (out_torque_current),
    .out_temp_reading   (out_temp_reading),
    .out_angle_deg      (out_angle_deg),
    .out_over_temp      (out_over_temp),
    .out_tx_group       (out_tx_group),
    .out_tx_slot        (out_tx_slot)
  );

endmodule

FILE: test/testbench.sv
// Self-checking bench for motor_feedback_decode_unwrap: directed and random feedback
// frames, checked word by word against an in-bench model of the unwrap and decode.
// Depends on mfdu_pkg and the motor_feedback_decode_unwrap RTL only.
module testbench;
  import mfdu_pkg::*;

  localparam int LATENCY     = 5;
  localparam int QUIET_LIMIT = 1000;
  localparam int PHASES      = 8;
  localparam int PHASE_WORDS = 90;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [6:0][7:0] data;
  } frame_t;

  typedef struct packed {
    fb_t         fb;
    logic [47:0] angle;
  } feedback_word_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [10:0] in_frame_id = '0;
  logic [7:0]  in_data_b0 = '0, in_data_b1 = '0, in_data_b2 = '0, in_data_b3 = '0;
  logic [7:0]  in_data_b4 = '0, in_data_b5 = '0, in_data_b6 = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_matched;
  logic [15:0] out_encoder_pos;
  logic signed [15:0] out_speed;
  logic signed [15:0] out_torque_current;
  logic [7:0]  out_temp_reading;
  logic signed [47:0] out_angle_deg;
  logic        out_over_temp;
  logic [1:0]  out_tx_group;
  logic [3:0]  out_tx_slot;

  // Register copies and decoder state as the bench tracks them.
  logic [ID_W-1:0]  cf_rx_id = RST_RX_ID;
  mtype_t           cf_mtype = MT_GEARED_A;
  logic [DEG_W-1:0] cf_deg = RST_DEG;
  logic [7:0]       cf_temp_limit = RST_TEMP_LIMIT;
  logic [HOT_W-1:0] cf_count_limit = RST_COUNT_LIMIT;

  logic             fb_started = 1'b0;
  logic [15:0]      fb_prev_enc = '0;
  longint           fb_turns = 0;
  logic [HOT_W-1:0] fb_hot_frames = '0;
  logic             fb_hot_flag = 1'b0;
  logic [15:0]      fb_enc = '0, fb_speed = '0, fb_current = '0;
  logic [7:0]       fb_temp = '0;
  grp_t             fb_group = GRP_NONE;
  logic [3:0]       fb_slot = '0;

  feedback_word_t pending_feedback[$];
  int  errors = 0;
  int  words_seen = 0;
  int  quiet_cycles = 0;
  int  recv_wait = 0;
  int  hold_left = 0;
  bit  idle_on = 1'b1;
  int  last_enc = 0;

  motor_feedback_decode_unwrap dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Degrees from the turn count: magnitude times scale, rounded off at 16 bits, saturated.
  function automatic logic [47:0] scale_turns(longint turns);
    logic        neg;
    logic [63:0] mag, hi, lo, r;
    neg = turns < 0;
    mag = neg ? 64'(-turns) : 64'(turns);
    hi = 64'(cf_deg >> 16);
    lo = 64'(cf_deg[15:0]);
    r = mag * hi + ((mag * lo + 64'h8000) >> 16);
    if (neg) begin
      if (r > (64'd1 << 47)) r = 64'd1 << 47;
      r = -r;
    end else if (r > 64'(CNT_MAX)) begin
      r = 64'(CNT_MAX);
    end
    return r[47:0];
  endfunction

  // Advance the tracked state by one frame and give the word the block should send.
  function automatic feedback_word_t track_frame(frame_t f);
    feedback_word_t w;
    logic [15:0] enc;
    int     d, turn_step, alt, abs_alt, abs_d, rid;
    longint sum;
    if (f.id == cf_rx_id) begin
      enc = {f.data[0], f.data[1]};
      fb_enc = enc;
      fb_speed = {f.data[2], f.data[3]};
      fb_current = {f.data[4], f.data[5]};
      fb_temp = f.data[6];

      // Hot frames count up while above the limit; passing the count limit latches the flag.
      if (fb_temp > cf_temp_limit) begin
        if (fb_hot_frames != {HOT_W{1'b1}}) fb_hot_frames++;
        if (fb_hot_frames > cf_count_limit) begin
          fb_hot_flag = 1'b1;
          fb_hot_frames = '0;
        end
      end else begin
        fb_hot_frames = '0;
      end

      // Command group and slot follow the identifier until tracking has started.
      if (!fb_started) begin
        rid = int'(cf_rx_id);
        if (cf_rx_id > RX_MIDDLE) begin
          fb_group = (cf_mtype == MT_SINGLE) ? GRP_VOLT : GRP_HIGH;
          fb_slot = 4'(2 * (rid - int'(RX_MIDDLE) - 1));
        end else if (cf_rx_id > RX_LOW) begin
          fb_group = GRP_LOW;
          fb_slot = 4'(2 * (rid - int'(RX_LOW) - 1));
        end
      end

      // Unwrap the encoder step into the multi-turn count.
      if (cf_mtype != MT_NO_ANGLE) begin
        if (!fb_started) begin
          fb_prev_enc = enc;
          fb_turns = (cf_mtype == MT_SINGLE) ? longint'(enc) : 0;
          fb_started = 1'b1;
        end
        d = int'(enc) - int'(fb_prev_enc);
        if (cf_mtype == MT_SINGLE) begin
          turn_step = d;
          if (2 * d > ENC_COUNTS) turn_step = d - ENC_COUNTS;
          else if (2 * d < -ENC_COUNTS) turn_step = d + ENC_COUNTS;
        end else begin
          alt = 0;
          if (d < 0) alt = d + ENC_COUNTS;
          else if (d > 0) alt = d - ENC_COUNTS;
          abs_alt = (alt < 0) ? -alt : alt;
          abs_d = (d < 0) ? -d : d;
          turn_step = (abs_alt > abs_d) ? d : alt;
        end
        fb_prev_enc = enc;
        sum = fb_turns + longint'(turn_step);
        if (sum > longint'(CNT_MAX)) sum = longint'(CNT_MAX);
        if (sum < longint'(CNT_MIN)) sum = longint'(CNT_MIN);
        fb_turns = sum;
      end
    end
    w.fb.matched = (f.id == cf_rx_id);
    w.fb.encoder = fb_enc;
    w.fb.speed = fb_speed;
    w.fb.current = fb_current;
    w.fb.temp = fb_temp;
    w.fb.over_temp = fb_hot_flag;
    w.fb.group = fb_group;
    w.fb.slot = fb_slot;
    w.angle = scale_turns(fb_turns);
    return w;
  endfunction

  function automatic frame_t make_frame(logic [10:0] id, logic [15:0] enc, logic [15:0] spd,
                                        logic [15:0] cur, logic [7:0] temp);
    frame_t f;
    f.id = id;
    f.data = {temp, cur[7:0], cur[15:8], spd[7:0], spd[15:8], enc[7:0], enc[15:8]};
    return f;
  endfunction

  // Register write; the bench copy follows at once since writes happen only when idle.
  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_RX_ID:            cf_rx_id = value[ID_W-1:0];
      CFG_MOTOR_TYPE:       cf_mtype = mtype_t'(value[1:0]);
      CFG_DEG_PER_COUNT:    cf_deg = value;
      CFG_TEMP_LIMIT:       cf_temp_limit = value[7:0];
      CFG_TEMP_COUNT_LIMIT: cf_count_limit = value[HOT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one frame after a random gap and hold it until the block takes it.
  task automatic send_frame(frame_t f);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid <= 1'b1;
    in_frame_id <= f.id;
    in_data_b0 <= f.data[0];
    in_data_b1 <= f.data[1];
    in_data_b2 <= f.data[2];
    in_data_b3 <= f.data[3];
    in_data_b4 <= f.data[4];
    in_data_b5 <= f.data[5];
    in_data_b6 <= f.data[6];
    do @(posedge clk); while (in_stall);
    pending_feedback.push_back(track_frame(f));
  endtask

  // Stop offering and wait for every expected word, then let the pipeline settle.
  task automatic drain_words();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_feedback.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic report_mismatch(string what);
    errors++;
    if (errors <= 100) $display("ERROR word %0d: %s", words_seen, what);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Output side: compare each accepted word with the oldest expectation.
  always @(posedge clk) begin : check_words
    feedback_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (pending_feedback.size() == 0) begin
        report_mismatch("word arrived with none expected");
      end else begin
        want = pending_feedback.pop_front();
        check_field("matched", 64'(out_matched), 64'(want.fb.matched));
        check_field("encoder_pos", 64'(out_encoder_pos), 64'(want.fb.encoder));
        check_field("speed", 64'(out_speed[15:0]), 64'(want.fb.speed));
        check_field("torque_current", 64'(out_torque_current[15:0]),
                    64'(want.fb.current));
        check_field("temp_reading", 64'(out_temp_reading), 64'(want.fb.temp));
        check_field("angle_deg", 64'(out_angle_deg[47:0]), 64'(want.angle));
        check_field("over_temp", 64'(out_over_temp), 64'(want.fb.over_temp));
        check_field("tx_group", 64'(out_tx_group), 64'(want.fb.group));
        check_field("tx_slot", 64'(out_tx_slot), 64'(want.fb.slot));
      end
      recv_wait = idle_on ? $urandom_range(0, 5) : 0;
    end
  end

  // Receiver stall: a long hold when asked, otherwise the per-word wait.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: too long without a word moving on either side ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d idle cycles", quiet_cycles);
        $display("status: fail");
        $finish;
      end
    end
  end

  // Frames for identifiers other than the reset one must show the cleared state.
  task automatic test_reset_state();
    send_frame(make_frame(11'h000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_frame(make_frame(11'h200, 16'h1234, 16'h8000, 16'h7FFF, 8'h80));
    drain_words();
  endtask

  // First frame in single-turn mode, half-turn ties and wraps in both directions.
  task automatic test_single_turn();
    write_reg(CFG_RX_ID, 32'h7FF);
    write_reg(CFG_MOTOR_TYPE, 32'(MT_SINGLE));
    write_reg(CFG_DEG_PER_COUNT, 32'hFFFF_FFFF);
    write_reg(CFG_TEMP_LIMIT, 32'd255);
    write_reg(CFG_TEMP_COUNT_LIMIT, 32'd1023);
    send_frame(make_frame(11'h7FF, 16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF));
    send_frame(make_frame(11'h7FF, 16'hEFFF, 16'h7FFF, 16'h8000, 8'h00));
    send_frame(make_frame(11'h7FF, 16'hFFFF, 16'h0000, 16'hFFFF, 8'h01));
    send_frame(make_frame(11'h7FF, 16'h0000, 16'hFFFF, 16'h0000, 8'hFE));
    send_frame(make_frame(11'h7FF, 16'h1001, 16'h0001, 16'h0001, 8'h10));
    send_frame(make_frame(11'h7FF, 16'h0000, 16'h8001, 16'hFFFE, 8'h20));
    send_frame(make_frame(11'h7FE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    drain_words();
  endtask

  // Accumulate unwrap: a half-turn tie takes the wrapped step; zero and plain steps.
  task automatic test_accumulate();
    write_reg(CFG_MOTOR_TYPE, 32'(MT_GEARED_A));
    write_reg(CFG_DEG_PER_COUNT, 32'(RST_DEG));
    send_frame(make_frame(11'h7FF, 16'h1000, 16'h0100, 16'hFF00, 8'h30));
    send_frame(make_frame(11'h7FF, 16'h0000, 16'h0200, 16'hFE00, 8'h31));
    send_frame(make_frame(11'h7FF, 16'h0000, 16'h0300, 16'hFD00, 8'h32));
    send_frame(make_frame(11'h7FF, 16'h1388, 16'h0400, 16'hFC00, 8'h33));
    drain_words();
    write_reg(CFG_MOTOR_TYPE, 32'(MT_GEARED_B));
    send_frame(make_frame(11'h7FF, 16'h1000, 16'h0500, 16'hFB00, 8'h34));
    drain_words();
  endtask

  // No-angle mode leaves the count alone and decodes group and slot on every frame.
  task automatic test_no_angle();
    logic [10:0] ids[5];
    ids = '{11'h201, 11'h204, 11'h200, 11'h205, 11'h000};
    write_reg(CFG_MOTOR_TYPE, 32'(MT_NO_ANGLE));
    foreach (ids[i]) begin
      write_reg(CFG_RX_ID, 32'(ids[i]));
      send_frame(make_frame(ids[i], 16'(i * 1000), 16'hFFFF, 16'h0000, 8'(i)));
      drain_words();
    end
  endtask

  // Hot frames: a cool frame clears the run, the third hot frame in a row sets the flag.
  task automatic test_over_temp();
    logic [7:0] temps[6];
    temps = '{8'd101, 8'd101, 8'd100, 8'd101, 8'd101, 8'd101};
    write_reg(CFG_RX_ID, 32'h203);
    write_reg(CFG_MOTOR_TYPE, 32'(MT_GEARED_A));
    write_reg(CFG_TEMP_LIMIT, 32'd100);
    write_reg(CFG_TEMP_COUNT_LIMIT, 32'd2);
    foreach (temps[i])
      send_frame(make_frame(11'h203, 16'(100 * i), 16'(i), 16'(-i), temps[i]));
    drain_words();
  endtask

  // Next encoder reading: mostly a drift in one direction, some half-turn jumps, a few wild.
  function automatic logic [15:0] next_encoder(int dir);
    int r, e;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      e = int'($urandom_range(0, 65535));
    end else begin
      if (r < 15)
        e = last_enc + ($urandom_range(0, 1) ? 4096 : -4096) + int'($urandom_range(0, 2)) - 1;
      else
        e = last_enc + dir * int'($urandom_range(0, 3000)) + int'($urandom_range(0, 400)) - 200;
      e = ((e % ENC_COUNTS) + ENC_COUNTS) % ENC_COUNTS;
    end
    last_enc = e;
    return 16'(e);
  endfunction

  function automatic frame_t random_frame(int dir);
    frame_t f;
    int t;
    if ($urandom_range(0, 9) == 0) f.id = 11'($urandom_range(0, 2047));
    else f.id = cf_rx_id;
    f.data = 56'({$urandom, $urandom});
    {f.data[0], f.data[1]} = next_encoder(dir);
    if ($urandom_range(0, 1)) begin
      t = int'(cf_temp_limit) + int'($urandom_range(0, 2)) - 1;
      f.data[6] = (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : 8'(t);
    end
    return f;
  endfunction

  // Random phases, each with its own register setting, drift direction and idling.
  task automatic test_random_frames();
    int     matched_sent, dir;
    frame_t f;
    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_RX_ID, (p == 0) ? 32'd0 : (p == 7) ? 32'h7FF : $urandom_range(0, 2047));
      write_reg(CFG_MOTOR_TYPE, 32'(p % 4));
      write_reg(CFG_DEG_PER_COUNT, (p == 2) ? 32'd0 : (p == 5) ? 32'hFFFF_FFFF :
                                   (p == 1) ? $urandom_range(1, 1000) : $urandom);
      write_reg(CFG_TEMP_LIMIT, (p == 3) ? 32'd0 : (p == 6) ? 32'd255 : $urandom_range(0, 255));
      write_reg(CFG_TEMP_COUNT_LIMIT, (p == 4) ? 32'd0 : (p == 7) ? 32'd1023 :
                                      $urandom_range(0, 20));
      idle_on = (p % 3 != 2);
      dir = (p % 2) ? -1 : 1;
      matched_sent = 0;
      while (matched_sent < PHASE_WORDS) begin
        f = random_frame(dir);
        if (f.id == cf_rx_id) matched_sent++;
        send_frame(f);
      end
      drain_words();
    end
    idle_on = 1'b1;
  endtask

  // Receiver holds off for a long stretch while frames keep coming, so the block backs up.
  task automatic test_stalled_output();
    idle_on = 1'b0;
    hold_left = HOLD_CYCLES;
    repeat (30) send_frame(random_frame(1));
    drain_words();
    idle_on = 1'b1;
  endtask

  initial begin : run
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_reset_state();
    test_no_angle();
    test_single_turn();
    test_accumulate();
    test_over_temp();
    test_random_frames();
    test_stalled_output();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mfdu_pkg.sv
rtl/mfdu_track.sv
rtl/mfdu_scale.sv
rtl/motor_feedback_decode_unwrap.sv
test/testbench.sv
